/* sv/triangular_matrix_product_macros.svh */
`ifndef TRIANGULAR_MATRIX_PRODUCT_MACROS_SVH
`define TRIANGULAR_MATRIX_PRODUCT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TRIMP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRIMP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/trimp_pkg.sv */
package trimp_pkg;

  localparam int unsigned MAX_SIZE_DEF  = 16;
  localparam int unsigned ELEM_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned OPC_W   = 2;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned SIZE_W  = 5;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned PROD_W  = 36;
  localparam int unsigned TRI_W   = 8;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  localparam logic [OPC_W-1:0] OPC_WR_LOWER = 2'd0;
  localparam logic [OPC_W-1:0] OPC_WR_UPPER = 2'd1;
  localparam logic [OPC_W-1:0] OPC_QUERY    = 2'd2;

  localparam logic [APB_AW-3:0] REG_MATRIX_SIZE = '0;
  localparam logic [SIZE_W-1:0] SIZE_RESET      = 5'd16;

  typedef enum logic [1:0] {
    CMD_WR_LOWER,
    CMD_WR_UPPER,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic               zero;
  } cmd_ctl_t;

  // packed triangular address: big*(big+1)/2 + sml
  function automatic logic [TRI_W-1:0] tri_index(input logic [IDX_W-1:0] big,
                                                 input logic [IDX_W-1:0] sml);
    logic [TRI_W:0] prod;
    prod = {5'b0, big} * ({5'b0, big} + 9'd1);
    return TRI_W'(prod >> 1) + TRI_W'(sml);
  endfunction

endpackage

/* sv/triangular_matrix_product.sv */
// Triangular matrix product: holds a lower matrix L and an upper matrix U in two packed
// single-port-write RAMs and answers queries for one element of L*U. A front stage takes
// the input beat, drops writes outside the triangle or the size in use, and
// queues the rest in a two-entry command queue; the back stage executes them in order.
// A write leaves the queue as soon as the back stage is idle. A query walks its terms
// through one shared multiply-accumulate, one term per cycle, in the back stage: RAM
// read and multiplier, drain, then result load; a query outside the size in use skips
// straight to the result load and returns zero. The result sits in an output register,
// so input beats keep flowing into the queue while it waits. The stores are not cleared
// by reset: every entry a query touches must have been written first.
module triangular_matrix_product #(
  parameter int unsigned MAX_SIZE  = trimp_pkg::MAX_SIZE_DEF,
  parameter int unsigned ELEM_BITS = trimp_pkg::ELEM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [trimp_pkg::OPC_W-1:0]          in_opcode,
  input  logic [trimp_pkg::IDX_W-1:0]          in_row,
  input  logic [trimp_pkg::IDX_W-1:0]          in_col,
  input  logic signed [trimp_pkg::VALUE_W-1:0] in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [trimp_pkg::PROD_W-1:0]  out_product,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [trimp_pkg::APB_AW-1:0]         paddr,
  input  logic [trimp_pkg::APB_DW-1:0]         pwdata,
  output logic [trimp_pkg::APB_DW-1:0]         prdata,
  output logic                                 pready
);

  localparam int unsigned DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CTL_W = $bits(trimp_pkg::cmd_ctl_t);
  localparam int unsigned QW    = CTL_W + ELEM_BITS;

  logic                        q_not_full, q_push, q_not_empty, q_pop;
  trimp_pkg::cmd_ctl_t         f_ctl, b_ctl;
  logic [ELEM_BITS-1:0]        f_data, b_data;
  logic [QW-1:0]               q_dout;

  logic                        l_we, u_we;
  logic [AW-1:0]               l_waddr, l_raddr, u_waddr, u_raddr;
  logic [ELEM_BITS-1:0]        l_wdata, l_rdata, u_wdata, u_rdata;

  trimp_front #(
    .MAX_SIZE  (MAX_SIZE),
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_ctl      (f_ctl),
    .q_data     (f_data)
  );

  trimp_fifo #(
    .WIDTH (QW),
    .DEPTH (trimp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       ({f_ctl, f_data}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .dout      (q_dout)
  );

  assign b_ctl  = q_dout[QW-1:ELEM_BITS];
  assign b_data = q_dout[ELEM_BITS-1:0];

  trimp_back #(
    .MAX_SIZE  (MAX_SIZE),
    .ELEM_BITS (ELEM_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_not_empty),
    .cmd_ctl     (b_ctl),
    .cmd_data    (b_data),
    .cmd_pop     (q_pop),
    .l_we        (l_we),
    .l_waddr     (l_waddr),
    .l_wdata     (l_wdata),
    .l_raddr     (l_raddr),
    .l_rdata     (l_rdata),
    .u_we        (u_we),
    .u_waddr     (u_waddr),
    .u_wdata     (u_wdata),
    .u_raddr     (u_raddr),
    .u_rdata     (u_rdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_product (out_product)
  );

  trimp_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_lower_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  trimp_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_upper_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

endmodule

/* sv/trimp_ram.sv */
module trimp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 136,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/trimp_fifo.sv */
`include "triangular_matrix_product_macros.svh"

module trimp_fifo #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = trimp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] dout
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign not_full  = (count_r != CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `TRIMP_ASSERT_NOW(a_no_pop_empty, pop, count_r != '0, "queue popped while empty")
  `TRIMP_ASSERT_NOW(a_no_push_full, push, count_r != CW'(DEPTH), "queue pushed while full")
  `TRIMP_ASSERT_NEXT(a_push_holds, push && !pop, count_r != '0, "queue lost a pushed beat")

endmodule

/* sv/trimp_front.sv */
module trimp_front #(
  parameter int unsigned MAX_SIZE  = trimp_pkg::MAX_SIZE_DEF,
  parameter int unsigned ELEM_BITS = trimp_pkg::ELEM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [trimp_pkg::OPC_W-1:0]          in_opcode,
  input  logic [trimp_pkg::IDX_W-1:0]          in_row,
  input  logic [trimp_pkg::IDX_W-1:0]          in_col,
  input  logic signed [trimp_pkg::VALUE_W-1:0] in_value,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [trimp_pkg::APB_AW-1:0]         paddr,
  input  logic [trimp_pkg::APB_DW-1:0]         pwdata,
  output logic [trimp_pkg::APB_DW-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 q_not_full,
  output logic                                 q_push,
  output trimp_pkg::cmd_ctl_t                  q_ctl,
  output logic [ELEM_BITS-1:0]                 q_data
);

  localparam int unsigned SW = trimp_pkg::SIZE_W;

  logic [SW-1:0]                 size_r, size_nxt;
  logic [SW-1:0]                 n_used;
  logic                          accept;
  logic                          row_in, col_in;
  logic                          reg_hit;
  logic signed [31:0]            value_ext;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[trimp_pkg::APB_AW-1:2] == trimp_pkg::REG_MATRIX_SIZE);
  assign prdata  = reg_hit ? trimp_pkg::APB_DW'(size_r) : '0;

  always_comb begin
    size_nxt = size_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      size_nxt = pwdata[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= trimp_pkg::SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  // size in use saturates at MAX_SIZE
  assign n_used    = (32'(size_r) > MAX_SIZE) ? SW'(MAX_SIZE) : size_r;
  assign row_in    = ({1'b0, in_row} < n_used);
  assign col_in    = ({1'b0, in_col} < n_used);
  assign accept    = in_valid && in_ready;
  assign in_ready  = q_not_full;
  assign value_ext = 32'(in_value);
  assign q_data    = value_ext[ELEM_BITS-1:0];

  always_comb begin
    q_push     = 1'b0;
    q_ctl.kind = trimp_pkg::CMD_QUERY;
    q_ctl.row  = in_row;
    q_ctl.col  = in_col;
    q_ctl.zero = !(row_in && col_in);
    unique case (in_opcode)
      trimp_pkg::OPC_WR_LOWER: begin
        q_ctl.kind = trimp_pkg::CMD_WR_LOWER;
        q_push     = accept && (in_row >= in_col) && row_in;
      end
      trimp_pkg::OPC_WR_UPPER: begin
        q_ctl.kind = trimp_pkg::CMD_WR_UPPER;
        q_push     = accept && (in_row <= in_col) && col_in;
      end
      trimp_pkg::OPC_QUERY: begin
        q_push = accept;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

/* sv/trimp_back.sv */
`include "triangular_matrix_product_macros.svh"

module trimp_back #(
  parameter int unsigned MAX_SIZE  = trimp_pkg::MAX_SIZE_DEF,
  parameter int unsigned ELEM_BITS = trimp_pkg::ELEM_BITS_DEF,
  localparam int unsigned DEPTH    = MAX_SIZE * (MAX_SIZE + 1) / 2,
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_valid,
  input  trimp_pkg::cmd_ctl_t                 cmd_ctl,
  input  logic [ELEM_BITS-1:0]                cmd_data,
  output logic                                cmd_pop,
  output logic                                l_we,
  output logic [AW-1:0]                       l_waddr,
  output logic [ELEM_BITS-1:0]                l_wdata,
  output logic [AW-1:0]                       l_raddr,
  input  logic [ELEM_BITS-1:0]                l_rdata,
  output logic                                u_we,
  output logic [AW-1:0]                       u_waddr,
  output logic [ELEM_BITS-1:0]                u_wdata,
  output logic [AW-1:0]                       u_raddr,
  input  logic [ELEM_BITS-1:0]                u_rdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [trimp_pkg::PROD_W-1:0] out_product
);

  localparam int unsigned IW = trimp_pkg::IDX_W;
  localparam int unsigned PW = trimp_pkg::PROD_W;
  localparam int unsigned MW = 2 * ELEM_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_DONE} state_t;

  state_t                state_r;
  logic [IW-1:0]         row_r, col_r, last_r, k_r;
  logic                  rd_v_r, mul_v_r, out_valid_r;
  logic [PW-1:0]         out_product_r;
  logic signed [MW-1:0]  mul_r;
  logic [PW-1:0]         acc_r;
  logic signed [63:0]    mul_ext;
  logic                  idle_head;
  logic                  is_query;

  assign idle_head = cmd_valid && (state_r == ST_IDLE);
  assign is_query  = (cmd_ctl.kind == trimp_pkg::CMD_QUERY);
  assign cmd_pop   = idle_head;

  assign l_we    = idle_head && (cmd_ctl.kind == trimp_pkg::CMD_WR_LOWER);
  assign u_we    = idle_head && (cmd_ctl.kind == trimp_pkg::CMD_WR_UPPER);
  assign l_waddr = AW'(trimp_pkg::tri_index(cmd_ctl.row, cmd_ctl.col));
  assign u_waddr = AW'(trimp_pkg::tri_index(cmd_ctl.col, cmd_ctl.row));
  assign l_wdata = cmd_data;
  assign u_wdata = cmd_data;
  assign l_raddr = AW'(trimp_pkg::tri_index(row_r, k_r));
  assign u_raddr = AW'(trimp_pkg::tri_index(col_r, k_r));

  assign out_valid   = out_valid_r;
  assign out_product = $signed(out_product_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r  <= (state_r == ST_ISSUE);
      mul_v_r <= rd_v_r;
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (idle_head && is_query) begin
            row_r   <= cmd_ctl.row;
            col_r   <= cmd_ctl.col;
            last_r  <= (cmd_ctl.row < cmd_ctl.col) ? cmd_ctl.row : cmd_ctl.col;
            k_r     <= '0;
            state_r <= cmd_ctl.zero ? ST_DONE : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_r == last_r) begin
            state_r <= ST_DRAIN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!rd_v_r && !mul_v_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_product_r <= acc_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign mul_ext = 64'(mul_r);

  always_ff @(posedge clk) begin
    mul_r <= $signed(l_rdata) * $signed(u_rdata);
    if (idle_head && is_query) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + mul_ext[PW-1:0];
    end
  end

  `TRIMP_ASSERT_NOW(a_write_idle, l_we || u_we, state_r == ST_IDLE, "store write outside idle")
  `TRIMP_ASSERT_NOW(a_issue_bound, state_r == ST_ISSUE, k_r <= last_r, "term index past diagonal")
  `TRIMP_ASSERT_NOW(a_done_drained, state_r == ST_DONE, !rd_v_r && !mul_v_r,
                    "result taken before pipeline drained")

endmodule
